// File: src/stack_calculator_checked_alu_unit_macros.svh
// Assertion macros for the stack calculator.
`ifndef STACK_CALCULATOR_CHECKED_ALU_UNIT_MACROS_SVH
`define STACK_CALCULATOR_CHECKED_ALU_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/sca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sca_pkg;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int VAR_SLOTS_DEF = 16;

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_POP = 4'd1;
	localparam logic [3:0] OP_PUSHL = 4'd2;
	localparam logic [3:0] OP_PUSHV = 4'd3;
	localparam logic [3:0] OP_STORE = 4'd4;
	localparam logic [3:0] OP_ABS = 4'd5;
	localparam logic [3:0] OP_ADD = 4'd6;
	localparam logic [3:0] OP_SUB = 4'd7;
	localparam logic [3:0] OP_MUL = 4'd8;
	localparam logic [3:0] OP_DIV = 4'd9;
	localparam logic [3:0] OP_PRINT = 4'd10;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FEW = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;
	localparam logic [2:0] ST_DIVZERO = 3'd5;
	localparam logic [2:0] ST_FULL = 3'd6;

	typedef logic [63:0] word_t;
endpackage
`default_nettype wire

// File: src/stack_calculator_checked_alu_unit.sv
// Checked 64-bit signed stack calculator. One command is taken per request and yields one
// result request with a status, and for print the top value. Stack and variables live in
// synchronous RAMs, so every command first passes an accept state and a read state that fetch
// the top two entries and the addressed variable. Nop, pop, push, store, abs, print, add and
// sub then finish in the execute state; multiply and divide run a bit-serial unit of 64
// iterations. A failed command leaves all state unchanged. The result sits in an output
// register; the next command is taken once that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_calculator_checked_alu_unit_macros.svh"
module stack_calculator_checked_alu_unit #(
	parameter int STACK_DEPTH = sca_pkg::STACK_DEPTH_DEF,
	parameter int VARIABLE_SLOTS = sca_pkg::VAR_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [3:0] mode,
	input wire logic signed [63:0] literal,
	input wire logic [3:0] var_index,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic print_valid,
	output logic signed [63:0] print_value
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int VW = (VARIABLE_SLOTS > 1) ? $clog2(VARIABLE_SLOTS) : 1;
	localparam logic [DW-1:0] FULL_D = DW'(STACK_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_ITER = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	logic [DW-1:0] depth_q;
	logic [VARIABLE_SLOTS-1:0] vvalid_q;
	logic [3:0] mode_q;
	sca_pkg::word_t lit_q;
	logic [3:0] vidx_q;

	sca_pkg::word_t stk_mem [STACK_DEPTH];
	sca_pkg::word_t var_mem [VARIABLE_SLOTS];
	sca_pkg::word_t top_q, sec_q, var_rd_q;
	logic [AW-1:0] rd_a_q, rd_b_q;
	logic [VW-1:0] vrd_q;

	logic st_we;
	logic [AW-1:0] st_wa;
	sca_pkg::word_t st_wd;
	logic v_we;

	// Iterative multiply/divide datapath.
	logic [6:0] cnt_q;
	logic [63:0] ma_q, mb_q, acc_q, quo_q;
	logic [64:0] rem_q;
	logic neg_q, ovf_q;

	logic [2:0] res_st_q;
	logic res_pv_q;
	sca_pkg::word_t res_val_q;

	logic slot_ok;
	assign slot_ok = (VARIABLE_SLOTS >= 16) ? 1'b1 : ({28'd0, vidx_q} < 32'(VARIABLE_SLOTS));
	logic [VW-1:0] slot;
	assign slot = VW'(vidx_q);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign status = res_st_q;
	assign print_valid = res_pv_q;
	assign print_value = res_val_q;

	always_ff @(posedge clk) begin
		top_q <= stk_mem[rd_a_q];
		sec_q <= stk_mem[rd_b_q];
		var_rd_q <= var_mem[vrd_q];
		if (st_we) begin
			stk_mem[st_wa] <= st_wd;
		end
		if (v_we) begin
			var_mem[slot] <= top_q;
		end
	end

	logic [63:0] sum, dif, mag_a, mag_b;
	assign sum = sec_q + top_q;
	assign dif = sec_q - top_q;
	assign mag_a = sec_q[63] ? -sec_q : sec_q;
	assign mag_b = top_q[63] ? -top_q : top_q;
	logic [64:0] rem_sh, rem_sub;
	assign rem_sh = {rem_q[63:0], ma_q[63]};
	assign rem_sub = rem_sh - {1'b0, mb_q};
	logic [64:0] acc_nx;
	assign acc_nx = {1'b0, acc_q} + (mb_q[0] ? {1'b0, ma_q} : 65'd0);

	// Combinational decision for single-step commands and for the final write of multiply and divide.
	logic [2:0] ex_st;
	always_comb begin
		st_we = 1'b0;
		st_wa = AW'(depth_q);
		st_wd = lit_q;
		v_we = 1'b0;
		ex_st = sca_pkg::ST_OK;
		if (state_q == S_EXEC) begin
			case (mode_q)
				sca_pkg::OP_POP: if (depth_q == '0) ex_st = sca_pkg::ST_EMPTY;
				sca_pkg::OP_PUSHL: begin
					if (depth_q == FULL_D) ex_st = sca_pkg::ST_FULL;
					else st_we = 1'b1;
				end
				sca_pkg::OP_PUSHV: begin
					if (!slot_ok || !vvalid_q[slot]) ex_st = sca_pkg::ST_UNKNOWN;
					else if (depth_q == FULL_D) ex_st = sca_pkg::ST_FULL;
					else begin
						st_we = 1'b1;
						st_wd = var_rd_q;
					end
				end
				sca_pkg::OP_STORE: begin
					if (depth_q == '0) ex_st = sca_pkg::ST_EMPTY;
					else if (!slot_ok) ex_st = sca_pkg::ST_UNKNOWN;
					else v_we = 1'b1;
				end
				sca_pkg::OP_ABS: begin
					if (depth_q == '0) ex_st = sca_pkg::ST_EMPTY;
					else if (top_q == 64'h8000_0000_0000_0000) ex_st = sca_pkg::ST_OVERFLOW;
					else begin
						st_we = 1'b1;
						st_wa = AW'(depth_q - DW'(1));
						st_wd = mag_b;
					end
				end
				sca_pkg::OP_ADD, sca_pkg::OP_SUB, sca_pkg::OP_MUL, sca_pkg::OP_DIV: begin
					if (depth_q == '0) ex_st = sca_pkg::ST_EMPTY;
					else if (depth_q == DW'(1)) ex_st = sca_pkg::ST_FEW;
					else if (mode_q == sca_pkg::OP_ADD) begin
						if (((sec_q ^ sum) & (top_q ^ sum)) >> 63 != 0)
							ex_st = sca_pkg::ST_OVERFLOW;
						else begin
							st_we = 1'b1;
							st_wa = AW'(depth_q - DW'(2));
							st_wd = sum;
						end
					end else if (mode_q == sca_pkg::OP_SUB) begin
						if (((sec_q ^ top_q) & (sec_q ^ dif)) >> 63 != 0)
							ex_st = sca_pkg::ST_OVERFLOW;
						else begin
							st_we = 1'b1;
							st_wa = AW'(depth_q - DW'(2));
							st_wd = dif;
						end
					end else if (mode_q == sca_pkg::OP_DIV && top_q == '0) begin
						ex_st = sca_pkg::ST_DIVZERO;
					end
				end
				sca_pkg::OP_PRINT: if (depth_q == '0) ex_st = sca_pkg::ST_EMPTY;
				default: ;
			endcase
		end else if (state_q == S_ITER && cnt_q == 7'd64) begin
			st_wa = AW'(depth_q - DW'(2));
			if (mode_q == sca_pkg::OP_MUL) begin
				st_wd = neg_q ? -acc_q : acc_q;
				st_we = !ovf_q && !(neg_q ? (acc_q > 64'h8000_0000_0000_0000)
					: acc_q[63]);
			end else begin
				st_wd = neg_q ? -quo_q : quo_q;
				st_we = !(quo_q[63] && !neg_q);
			end
		end
	end

	logic binop_ok;
	assign binop_ok = (depth_q > DW'(1)) &&
		((mode_q == sca_pkg::OP_MUL) || (mode_q == sca_pkg::OP_DIV && top_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			vvalid_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					if (binop_ok) begin
						state_q <= S_ITER;
						cnt_q <= '0;
					end else begin
						state_q <= S_DONE;
						if (ex_st == sca_pkg::ST_OK) begin
							if (mode_q == sca_pkg::OP_POP) depth_q <= depth_q - DW'(1);
							if (mode_q == sca_pkg::OP_PUSHL || mode_q == sca_pkg::OP_PUSHV)
								depth_q <= depth_q + DW'(1);
							if (mode_q == sca_pkg::OP_ADD || mode_q == sca_pkg::OP_SUB)
								depth_q <= depth_q - DW'(1);
							if (v_we) vvalid_q[slot] <= 1'b1;
						end
					end
				end
				S_ITER: begin
					if (cnt_q == 7'd64) begin
						state_q <= S_DONE;
						if (st_we) depth_q <= depth_q - DW'(1);
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode;
			lit_q <= literal;
			vidx_q <= var_index;
			vrd_q <= VW'(var_index);
			rd_a_q <= AW'(depth_q - DW'(1));
			rd_b_q <= AW'(depth_q - DW'(2));
		end
		if (state_q == S_EXEC) begin
			res_st_q <= ex_st;
			res_pv_q <= (mode_q == sca_pkg::OP_PRINT) && (ex_st == sca_pkg::ST_OK);
			res_val_q <= ((mode_q == sca_pkg::OP_PRINT) && (ex_st == sca_pkg::ST_OK))
				? top_q : '0;
			ma_q <= mag_a;
			mb_q <= mag_b;
			acc_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= sec_q[63] ^ top_q[63];
		end
		if (state_q == S_ITER && cnt_q != 7'd64) begin
			if (mode_q == sca_pkg::OP_MUL) begin
				// Shift-add over the multiplier bits, flagging any carry past 64 bits.
				if (acc_nx[64] || (mb_q[0] && ovf_q)) ovf_q <= 1'b1;
				if (ma_q[63] && (mb_q[63:1] != '0)) ovf_q <= 1'b1;
				acc_q <= acc_nx[63:0];
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end else begin
				// Restoring division, one quotient bit per cycle.
				if (!rem_sub[64]) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[62:0], 1'b0};
				end
				ma_q <= ma_q << 1;
			end
		end
		if (state_q == S_ITER && cnt_q == 7'd64) begin
			res_pv_q <= 1'b0;
			res_val_q <= '0;
			res_st_q <= st_we ? sca_pkg::ST_OK : sca_pkg::ST_OVERFLOW;
		end
	end

	`SCA_ASSERT_IMP(a_depth_range, clk, arst_n, 1'b1, depth_q <= FULL_D)
	`SCA_ASSERT_IMP(a_print_zero, clk, arst_n, out_valid && !print_valid, print_value == '0)
	`SCA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status))
endmodule
`default_nettype wire

// File: tb/stack_calculator_checked_alu_unit_tb.sv
`timescale 1ns / 1ps
module stack_calculator_checked_alu_unit_tb;
	localparam int STACK_MAX = sca_pkg::STACK_DEPTH_DEF;
	localparam int SLOTS = sca_pkg::VAR_SLOTS_DEF;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [63:0] MIN_WORD = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_WORD = 64'h7fff_ffff_ffff_ffff;

	typedef struct packed {
		logic [2:0] status;
		logic print_valid;
		logic [63:0] print_value;
	} calc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] mode = sca_pkg::OP_NOP;
	logic signed [63:0] literal = '0;
	logic [3:0] var_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic print_valid;
	logic signed [63:0] print_value;

	// Predictor state.
	logic [63:0] calc_stack [STACK_MAX];
	int calc_depth;
	logic [63:0] calc_vars [SLOTS];
	logic calc_var_set [SLOTS];

	calc_result_t expected_results [$];
	int error_count = 0;
	longint cycle_count = 0;
	bit stall_enable = 1'b1;

	stack_calculator_checked_alu_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .literal(literal), .var_index(var_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .print_valid(print_valid), .print_value(print_value)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] magnitude_of(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	// Works out the status of a binary operation and its value on success.
	function automatic logic [2:0] arith_result(logic [3:0] op, logic [63:0] a, logic [63:0] b,
			output logic [63:0] r);
		logic [63:0] ma, mb, lim, q;
		logic neg;
		r = '0;
		neg = a[63] ^ b[63];
		case (op)
			sca_pkg::OP_ADD: begin
				r = a + b;
				if (((a ^ r) & (b ^ r)) >> 63) return sca_pkg::ST_OVERFLOW;
			end
			sca_pkg::OP_SUB: begin
				r = a - b;
				if (((a ^ b) & (a ^ r)) >> 63) return sca_pkg::ST_OVERFLOW;
			end
			sca_pkg::OP_MUL: begin
				if (a == 0 || b == 0) return sca_pkg::ST_OK;
				ma = magnitude_of(a);
				mb = magnitude_of(b);
				lim = neg ? MIN_WORD : MAX_WORD;
				if (ma > lim / mb) return sca_pkg::ST_OVERFLOW;
				q = ma * mb;
				r = neg ? -q : q;
			end
			default: begin
				if (b == 0) return sca_pkg::ST_DIVZERO;
				if (a == MIN_WORD && b == '1) return sca_pkg::ST_OVERFLOW;
				q = magnitude_of(a) / magnitude_of(b);
				r = neg ? -q : q;
			end
		endcase
		return sca_pkg::ST_OK;
	endfunction

	function automatic calc_result_t predict_command(logic [3:0] op, logic [63:0] lit,
			logic [3:0] slot);
		calc_result_t res;
		logic [63:0] top, value;
		res = '0;
		top = (calc_depth > 0) ? calc_stack[calc_depth - 1] : '0;
		case (op)
			sca_pkg::OP_POP: begin
				if (calc_depth == 0) res.status = sca_pkg::ST_EMPTY;
				else calc_depth--;
			end
			sca_pkg::OP_PUSHL: begin
				if (calc_depth >= STACK_MAX) res.status = sca_pkg::ST_FULL;
				else begin
					calc_stack[calc_depth] = lit;
					calc_depth++;
				end
			end
			sca_pkg::OP_PUSHV: begin
				if (slot >= SLOTS || !calc_var_set[slot]) res.status = sca_pkg::ST_UNKNOWN;
				else if (calc_depth >= STACK_MAX) res.status = sca_pkg::ST_FULL;
				else begin
					calc_stack[calc_depth] = calc_vars[slot];
					calc_depth++;
				end
			end
			sca_pkg::OP_STORE: begin
				if (calc_depth == 0) res.status = sca_pkg::ST_EMPTY;
				else if (slot >= SLOTS) res.status = sca_pkg::ST_UNKNOWN;
				else begin
					calc_vars[slot] = top;
					calc_var_set[slot] = 1'b1;
				end
			end
			sca_pkg::OP_ABS: begin
				if (calc_depth == 0) res.status = sca_pkg::ST_EMPTY;
				else if (top == MIN_WORD) res.status = sca_pkg::ST_OVERFLOW;
				else calc_stack[calc_depth - 1] = magnitude_of(top);
			end
			sca_pkg::OP_ADD, sca_pkg::OP_SUB, sca_pkg::OP_MUL, sca_pkg::OP_DIV: begin
				if (calc_depth == 0) res.status = sca_pkg::ST_EMPTY;
				else if (calc_depth < 2) res.status = sca_pkg::ST_FEW;
				else begin
					res.status = arith_result(op, calc_stack[calc_depth - 2], top, value);
					if (res.status == sca_pkg::ST_OK) begin
						calc_stack[calc_depth - 2] = value;
						calc_depth--;
					end
				end
			end
			sca_pkg::OP_PRINT: begin
				if (calc_depth == 0) res.status = sca_pkg::ST_EMPTY;
				else begin
					res.print_valid = 1'b1;
					res.print_value = top;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Each request starts on a fresh clock edge, so the valid line is never driven twice at once.
	task automatic send_command(logic [3:0] op, logic [63:0] lit = '0, logic [3:0] slot = '0);
		@(posedge clk);
		while (stall_enable && $urandom_range(99) < 26) @(posedge clk);
		expected_results = {expected_results, predict_command(op, lit, slot)};
		in_valid <= 1'b1;
		mode <= op;
		literal <= lit;
		var_index <= slot;
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= !stall_enable || ($urandom_range(99) >= 26);
	end

	always @(posedge clk) begin
		calc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10) $display("unexpected result, status %0d", status);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || print_valid !== want.print_valid ||
						print_value !== want.print_value) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
							want.status, want.print_valid, $signed(want.print_value),
							status, print_valid, print_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [63:0] random_word();
		case ($urandom_range(5))
			0: return MIN_WORD;
			1: return MAX_WORD;
			2: return 64'($signed($urandom_range(20)) - 10);
			3: return {$urandom, $urandom} >> $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_empty_and_errors();
		send_command(sca_pkg::OP_POP);
		send_command(sca_pkg::OP_STORE, '0, 4'd3);
		send_command(sca_pkg::OP_ABS);
		send_command(sca_pkg::OP_ADD);
		send_command(sca_pkg::OP_DIV);
		send_command(sca_pkg::OP_PRINT);
		send_command(sca_pkg::OP_PUSHV, '0, 4'd15);
		send_command(4'd11);
		send_command(4'd15, '1, '1);
		send_command(sca_pkg::OP_NOP);
		send_command(sca_pkg::OP_PUSHL, 64'd7);
		send_command(sca_pkg::OP_MUL);
		send_command(sca_pkg::OP_SUB);
	endtask

	task automatic test_arith_edges();
		send_command(sca_pkg::OP_PUSHL, MIN_WORD);
		send_command(sca_pkg::OP_ABS);
		send_command(sca_pkg::OP_STORE, '0, 4'd15);
		send_command(sca_pkg::OP_PUSHL, '1);
		send_command(sca_pkg::OP_DIV);
		send_command(sca_pkg::OP_PUSHL, '0);
		send_command(sca_pkg::OP_DIV);
		send_command(sca_pkg::OP_POP);
		send_command(sca_pkg::OP_PUSHL, MAX_WORD);
		send_command(sca_pkg::OP_ADD);
		send_command(sca_pkg::OP_MUL);
		send_command(sca_pkg::OP_SUB);
		send_command(sca_pkg::OP_PUSHV, '0, 4'd15);
		send_command(sca_pkg::OP_PRINT);
		while (calc_depth > 0) send_command(sca_pkg::OP_POP);
	endtask

	task automatic test_full_stack();
		repeat (STACK_MAX) send_command(sca_pkg::OP_PUSHL, random_word());
		send_command(sca_pkg::OP_PUSHL, 64'd1);
		send_command(sca_pkg::OP_PUSHV, '0, 4'd15);
		while (calc_depth > 0) send_command(sca_pkg::OP_POP);
	endtask

	// Mostly well-formed programs: pushes followed by operations, with some noise.
	task automatic test_random_programs(int count);
		int r;
		logic [3:0] op;
		for (int n = 0; n < count; n++) begin
			stall_enable = !(n >= count / 3 && n < count / 3 + 150);
			r = $urandom_range(99);
			if (r < 30 || calc_depth < 2 && r < 60)
				op = $urandom_range(1) ? sca_pkg::OP_PUSHL : sca_pkg::OP_PUSHV;
			else if (r < 85) op = 4'($urandom_range(sca_pkg::OP_ADD, sca_pkg::OP_DIV));
			else op = 4'($urandom_range(15));
			send_command(op, random_word(), 4'($urandom_range(15)));
		end
		stall_enable = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		calc_depth = 0;
		foreach (calc_var_set[i]) calc_var_set[i] = 1'b0;
		test_empty_and_errors();
		test_arith_edges();
		test_full_stack();
		test_random_programs(700);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
